// ===== design/pcrg_pkg.sv =====
`default_nettype none
package pcrg_pkg;
  localparam int unsigned NormBits = 23;
  localparam int unsigned UnitOne  = 16384;
  localparam int unsigned SqrtSteps = 24;
  localparam int unsigned DivSteps  = 16;

  typedef enum logic [2:0] {
    RegFront  = 3'd0,
    RegUp     = 3'd1,
    RegRight  = 3'd2,
    RegOrigin = 3'd3,
    RegNear   = 3'd4,
    RegFar    = 3'd5,
    RegTan    = 3'd6,
    RegAspect = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] origin;
    logic [31:0] t_min;
    logic [31:0] t_max;
    logic        range_error;
  } side_t;
endpackage
`default_nettype wire

// ===== design/pcrg_norm.sv =====
`default_nettype none
// normalizes a vector of three signed 24-bit values to unit length, pipelined
module pcrg_norm (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [23:0]   e_i [3],
  input  wire logic                 zero_i,
  input  wire pcrg_pkg::side_t      side_i,
  output logic                      valid_o,
  output logic signed [15:0]        dir_o [3],
  output pcrg_pkg::side_t           side_o
);
  import pcrg_pkg::*;

  localparam int unsigned NS = SqrtSteps;
  localparam int unsigned ND = DivSteps;
  localparam int unsigned NT = 2 + NS + ND;

  logic [NT-1:0]          vld_q;
  logic                   z_q    [NT];
  side_t                  sd_q   [NT];
  logic [48:0]            s_q    [NT];
  logic [49:0]            rem_q  [NT];
  logic [24:0]            root_q [NT];
  logic [24:0]            len_q  [NT];
  logic [38:0]            num_q  [NT][3];
  logic [16:0]            quo_q  [NT][3];
  logic signed [23:0]     ev_q   [NT][3];

  // stage 0: squares
  logic [47:0] sq [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[k] = 48'(e_i[k]) * 48'(e_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 0
      for (int k = 0; k < 3; k++) begin
        ev_q[0][k] <= e_i[k];
      end
      z_q[0]  <= zero_i;
      sd_q[0] <= side_i;
      s_q[0]  <= 49'(sq[0]) + 49'(sq[1]) + 49'(sq[2]);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      // stage 1: setup sqrt
      ev_q[1]   <= ev_q[0];
      z_q[1]    <= z_q[0];
      sd_q[1]   <= sd_q[0];
      s_q[1]    <= s_q[0];
      rem_q[1]  <= '0;
      root_q[1] <= '0;
      // sqrt digit stages, two bits of radicand each
      for (int i = 2; i < 2 + NS; i++) begin
        logic [49:0] r2;
        logic [49:0] tr;
        r2 = {rem_q[i-1][47:0], s_q[i-1][2*(NS-1-(i-2))+1 -: 2]};
        tr = {23'd0, root_q[i-1], 2'b01};
        ev_q[i] <= ev_q[i-1];
        z_q[i]  <= z_q[i-1];
        sd_q[i] <= sd_q[i-1];
        s_q[i]  <= s_q[i-1];
        if (r2 >= tr) begin
          rem_q[i]  <= r2 - tr;
          root_q[i] <= {root_q[i-1][23:0], 1'b1};
        end else begin
          rem_q[i]  <= r2;
          root_q[i] <= {root_q[i-1][23:0], 1'b0};
        end
      end
      // division stages: q = (a*2^15 + L) / (2L), restoring, one quotient bit each
      for (int i = 2 + NS; i < NT; i++) begin
        logic [25:0] dv;
        ev_q[i] <= ev_q[i-1];
        z_q[i]  <= z_q[i-1];
        sd_q[i] <= sd_q[i-1];
        if (i == 2 + NS) begin
          len_q[i] <= root_q[i-1];
          dv = {root_q[i-1], 1'b0};
          for (int k = 0; k < 3; k++) begin
            logic [23:0] a;
            logic [38:0] n;
            logic [39:0] t;
            a = ev_q[i-1][k][23] ? 24'(-ev_q[i-1][k]) : 24'(ev_q[i-1][k]);
            n = {a, 15'd0} + 39'(root_q[i-1]);
            t = {14'd0, dv} << (ND - 1);
            if ({1'b0, n} >= t) begin
              num_q[i][k] <= 39'({1'b0, n} - t);
              quo_q[i][k] <= 17'd1;
            end else begin
              num_q[i][k] <= n;
              quo_q[i][k] <= 17'd0;
            end
          end
        end else begin
          len_q[i] <= len_q[i-1];
          dv = {len_q[i-1], 1'b0};
          for (int k = 0; k < 3; k++) begin
            logic [39:0] t;
            t = {14'd0, dv} << (NT - 1 - i);
            if ({1'b0, num_q[i-1][k]} >= t) begin
              num_q[i][k] <= 39'({1'b0, num_q[i-1][k]} - t);
              quo_q[i][k] <= {quo_q[i-1][k][15:0], 1'b1};
            end else begin
              num_q[i][k] <= num_q[i-1][k];
              quo_q[i][k] <= {quo_q[i-1][k][15:0], 1'b0};
            end
          end
        end
      end
    end
  end

  always_comb begin
    valid_o = vld_q[NT-1];
    side_o  = sd_q[NT-1];
    for (int k = 0; k < 3; k++) begin
      logic [16:0] q;
      q = (quo_q[NT-1][k] > 17'(UnitOne)) ? 17'(UnitOne) : quo_q[NT-1][k];
      if (z_q[NT-1] || len_q[NT-1] == '0) begin
        dir_o[k] = '0;
      end else if (ev_q[NT-1][k][23]) begin
        dir_o[k] = 16'(-$signed({1'b0, q}));
      end else begin
        dir_o[k] = 16'($signed({1'b0, q}));
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/pinhole_camera_ray_generator_unit.sv =====
`default_nettype none
// pinhole camera primary ray generator: one ndc pair per request in, one unit ray out.
// fully pipelined, one request per clock while the output is not stalled; a request passes
// 5 stages of scale and dot products, 2 for squares and root setup, 24 for the
// digit-per-stage square root, 16 for the bit-per-stage divide, then the output
// register. tvalid/tready with a global stall: the pipe advances when the output
// register is empty or taken.
// registers are written over apb at 8*index and must only change while idle.
module pinhole_camera_ray_generator_unit #(
  parameter int unsigned COORD_FRAC_BITS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // ndc_x, ndc_y
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [167:0]     m_axis_tdata,   // dir_x/y/z, origin_x/y/z, t_min, t_max, range_error
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import pcrg_pkg::*;

  logic [47:0] front_q, up_q, right_q, origin_q;
  logic [31:0] near_q, far_q, tan_q;
  logic [15:0] aspect_q;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      up_q     <= '0;
      right_q  <= '0;
      origin_q <= '0;
      near_q   <= 32'd6554;
      far_q    <= 32'd6553600;
      tan_q    <= 32'd27146;
      aspect_q <= 16'd455;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (idx)
        RegFront:  front_q  <= pwdata[47:0];
        RegUp:     up_q     <= pwdata[47:0];
        RegRight:  right_q  <= pwdata[47:0];
        RegOrigin: origin_q <= pwdata[47:0];
        RegNear:   near_q   <= pwdata[31:0];
        RegFar:    far_q    <= pwdata[31:0];
        RegTan:    tan_q    <= pwdata[31:0];
        RegAspect: aspect_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegFront:  prdata = {16'd0, front_q};
      RegUp:     prdata = {16'd0, up_q};
      RegRight:  prdata = {16'd0, right_q};
      RegOrigin: prdata = {16'd0, origin_q};
      RegNear:   prdata = {32'd0, near_q};
      RegFar:    prdata = {32'd0, far_q};
      RegTan:    prdata = {32'd0, tan_q};
      RegAspect: prdata = {48'd0, aspect_q};
      default:   prdata = '0;
    endcase
  end

  // stall control: output register
  logic en;
  logic out_v_q;
  logic [167:0] out_q;
  logic nv;
  logic signed [15:0] nd [3];
  side_t nside;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // front stages
  logic [4:0]         v_q;
  logic [31:0]        us_q;
  logic [31:0]        rs_q;
  logic signed [15:0] x_q [3];
  logic signed [15:0] y_q [2];
  side_t              sd_q [5];
  logic signed [48:0] fa_q [3];
  logic signed [48:0] ua_q [3];
  logic signed [48:0] ra_q [3];
  logic signed [63:0] up_p_q [3];
  logic signed [63:0] rt_p_q [3];
  logic signed [23:0] e_q [3];
  logic               z_q;

  localparam logic signed [21:0] One = 22'sd1 <<< COORD_FRAC_BITS;

  logic signed [15:0] xi, yi;
  assign xi = s_axis_tdata[15:0];
  assign yi = s_axis_tdata[31:16];

  function automatic logic signed [15:0] lane(input logic [47:0] p, input int k);
    lane = p[16*k +: 16];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [63:0] p0, p1;
      logic [63:0] mg;
      logic [63:0] m;
      logic [6:0]  b;
      // stage 0: us, register inputs
      p0 = 64'(near_q) * 64'(tan_q);
      us_q <= (p0[63:48] != 0) ? 32'hFFFF_FFFF : p0[47:16];
      x_q[0] <= xi;
      y_q[0] <= yi;
      sd_q[0].origin      <= origin_q;
      sd_q[0].t_min       <= near_q;
      sd_q[0].t_max       <= far_q;
      sd_q[0].range_error <= (22'(xi) < -One) || (22'(xi) > One)
                          || (22'(yi) < -One) || (22'(yi) > One);
      for (int k = 0; k < 3; k++) begin
        fa_q[k] <= 49'(lane(front_q, k)) * 49'($signed({1'b0, near_q}));
      end
      // stage 1: rs and u scale
      p1 = 64'(us_q) * 64'(aspect_q);
      rs_q <= (p1[63:40] != 0) ? 32'hFFFF_FFFF : p1[39:8];
      x_q[1] <= x_q[0];
      y_q[1] <= y_q[0];
      sd_q[1] <= sd_q[0];
      for (int k = 0; k < 3; k++) begin
        ua_q[k] <= 49'(lane(up_q, k)) * 49'($signed({1'b0, us_q}));
      end
      // stage 2: right scale, up times y
      x_q[2] <= x_q[1];
      sd_q[2] <= sd_q[1];
      for (int k = 0; k < 3; k++) begin
        ra_q[k]   <= 49'(lane(right_q, k)) * 49'($signed({1'b0, rs_q}));
        up_p_q[k] <= (64'(ua_q[k]) * 64'(y_q[1])) >>> COORD_FRAC_BITS;
      end
      // stage 3: right times x, sum
      sd_q[3] <= sd_q[2];
      for (int k = 0; k < 3; k++) begin
        rt_p_q[k] <= 64'(fa_q[k]) + up_p_q[k]
                   + ((64'(ra_q[k]) * 64'(x_q[2])) >>> COORD_FRAC_BITS);
      end
      // stage 4: bit length and normalize
      sd_q[4] <= sd_q[3];
      m = '0;
      for (int k = 0; k < 3; k++) begin
        mg = rt_p_q[k][63] ? 64'(-rt_p_q[k]) : 64'(rt_p_q[k]);
        m  = m | mg;
      end
      b = '0;
      for (int i = 0; i < 64; i++) begin
        if (m[i]) b = 7'(i + 1);
      end
      z_q <= (m == '0);
      for (int k = 0; k < 3; k++) begin
        if (b <= 7'(NormBits)) begin
          e_q[k] <= 24'(rt_p_q[k] <<< (7'(NormBits) - b));
        end else begin
          e_q[k] <= 24'(rt_p_q[k] >>> (b - 7'(NormBits)));
        end
      end
    end
  end

  pcrg_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[4]),
    .e_i     (e_q),
    .zero_i  (z_q),
    .side_i  (sd_q[4]),
    .valid_o (nv),
    .dir_o   (nd),
    .side_o  (nside)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= nv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {7'd0, nside.range_error, nside.t_max, nside.t_min, nside.origin,
                nd[2], nd[1], nd[0]};
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stalled with empty output");
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384
                   && $signed(m_axis_tdata[15:0]) >= -16'sd16384)
    else $error("direction out of unit range");
`endif
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcrg_pkg::*;

  localparam int unsigned FRAC = 14;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [15:0] dir_x, dir_y, dir_z;
    logic [15:0] org_x, org_y, org_z;
    logic [31:0] t_min, t_max;
    logic        range_err;
  } ray_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;     // ndc_x, ndc_y
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;         // dir_x/y/z, origin_x/y/z, t_min, t_max, range_error
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  // camera registers as the predictor sees them
  logic [47:0] cam_front = '0, cam_up = '0, cam_right = '0, cam_origin = '0;
  logic [31:0] cam_near = 32'd6554, cam_far = 32'd6553600, cam_tan = 32'd27146;
  logic [15:0] cam_aspect = 16'd455;

  logic [31:0] ndc_q[$];
  ray_t        ray_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0, recv_stall = 0, hold_cnt = 0;
  int unsigned hold_asked = 0, hold_done = 0;
  bit          quiet = 1'b0;

  pinhole_camera_ray_generator_unit #(.COORD_FRAC_BITS(FRAC)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  function automatic longint lane(logic [47:0] p, int k);
    logic signed [15:0] v;
    v = p[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t predict_ray(logic [31:0] ndc);
    logic signed [15:0] nx, ny;
    longint x, y, one, f, u, r, vq;
    longint dsum[3], escl[3];
    longint unsigned us, rs, mx, mag, sq, len, a, q;
    int b;
    ray_t o;
    nx = ndc[15:0];
    ny = ndc[31:16];
    x = longint'(nx);
    y = longint'(ny);
    one = longint'(1) << FRAC;
    us = (longint'(cam_near) * longint'(cam_tan)) >> 16;
    if (us > 64'hFFFF_FFFF) us = 64'hFFFF_FFFF;
    rs = (us * longint'(cam_aspect)) >> 8;
    if (rs > 64'hFFFF_FFFF) rs = 64'hFFFF_FFFF;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      f = lane(cam_front, k) * longint'(cam_near);
      u = (lane(cam_up, k) * longint'(us) * y) >>> FRAC;
      r = (lane(cam_right, k) * longint'(rs) * x) >>> FRAC;
      dsum[k] = f + u + r;
      mag = (dsum[k] < 0) ? 64'd0 - longint'(dsum[k]) : longint'(dsum[k]);
      if (mag > mx) mx = mag;
    end
    b = 0;
    while (b < 64 && (mx >> b) != 0) b++;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      if (b <= NormBits) escl[k] = dsum[k] <<< (NormBits - b);
      else escl[k] = dsum[k] >>> (b - NormBits);
      sq += longint'(escl[k] * escl[k]);
    end
    len = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      vq = 0;
      if (mx != 0 && len != 0) begin
        a = (escl[k] < 0) ? longint'(-escl[k]) : longint'(escl[k]);
        q = ((a << 15) + len) / (2 * len);
        if (q > UnitOne) q = UnitOne;
        vq = (escl[k] < 0) ? -longint'(q) : longint'(q);
      end
      if (k == 0) o.dir_x = vq[15:0];
      else if (k == 1) o.dir_y = vq[15:0];
      else o.dir_z = vq[15:0];
    end
    o.org_x = cam_origin[15:0];
    o.org_y = cam_origin[31:16];
    o.org_z = cam_origin[47:32];
    o.t_min = cam_near;
    o.t_max = cam_far;
    o.range_err = (x < -one || x > one || y < -one || y > one);
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, e, a);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin : drive
      logic nv;
      nv = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        ray_q.push_back(predict_ray(s_axis_tdata));
        void'(ndc_q.pop_front());
        send_gap = quiet ? 0 : pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
      end else if (ndc_q.size() > 0) begin
        nv = 1'b1;
        s_axis_tdata <= ndc_q[0];
      end
      s_axis_tvalid <= nv;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin : recv
      logic nr;
      ray_t e;
      if (m_axis_tvalid && m_axis_tready) begin
        if (ray_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: ray with no request pending");
        end else begin
          e = ray_q.pop_front();
          check_field("dir_x", e.dir_x, m_axis_tdata[15:0]);
          check_field("dir_y", e.dir_y, m_axis_tdata[31:16]);
          check_field("dir_z", e.dir_z, m_axis_tdata[47:32]);
          check_field("origin_x", e.org_x, m_axis_tdata[63:48]);
          check_field("origin_y", e.org_y, m_axis_tdata[79:64]);
          check_field("origin_z", e.org_z, m_axis_tdata[95:80]);
          check_field("t_min", e.t_min, m_axis_tdata[127:96]);
          check_field("t_max", e.t_max, m_axis_tdata[159:128]);
          check_field("range_error", e.range_err, m_axis_tdata[160]);
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_cnt = 300;
      end
      nr = 1'b1;
      if (hold_cnt > 0) begin
        hold_cnt--;
        nr = 1'b0;
      end else if (!quiet) begin
        if (recv_stall > 0) begin
          recv_stall--;
          nr = 1'b0;
        end else begin
          recv_stall = pick_gap();
        end
      end
      m_axis_tready <= nr;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(8 * int'(idx));
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegFront:  cam_front = val[47:0];
      RegUp:     cam_up = val[47:0];
      RegRight:  cam_right = val[47:0];
      RegOrigin: cam_origin = val[47:0];
      RegNear:   cam_near = val[31:0];
      RegFar:    cam_far = val[31:0];
      RegTan:    cam_tan = val[31:0];
      default:   cam_aspect = val[15:0];
    endcase
  endtask

  task automatic cfg_all(logic [63:0] fr, logic [63:0] up, logic [63:0] rt,
                         logic [63:0] org, logic [63:0] nr, logic [63:0] fa,
                         logic [63:0] tn, logic [63:0] asp);
    cfg_write(RegFront, fr);
    cfg_write(RegUp, up);
    cfg_write(RegRight, rt);
    cfg_write(RegOrigin, org);
    cfg_write(RegNear, nr);
    cfg_write(RegFar, fa);
    cfg_write(RegTan, tn);
    cfg_write(RegAspect, asp);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] vec3(int a, int b, int c);
    return {16'h0, 16'(c), 16'(b), 16'(a)};
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rnd_coord();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 32768) - 16384);
    return 16'($urandom);
  endfunction

  function automatic int rnd_lane();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  task automatic queue_directed();
    int pts[12][2] = '{'{0, 0}, '{16384, 16384}, '{-16384, -16384}, '{16384, -16384},
                       '{16385, 0}, '{0, -16385}, '{32767, -32768}, '{-32768, 32767},
                       '{8192, -4096}, '{-1, 1}, '{-16385, 16385}, '{12000, 0}};
    foreach (pts[i]) ndc_q.push_back({16'(pts[i][1]), 16'(pts[i][0])});
  endtask

  task automatic queue_random(int n);
    repeat (n) ndc_q.push_back({rnd_coord(), rnd_coord()});
  endtask

  task automatic wait_drained();
    while (ndc_q.size() != 0 || ray_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values: zero basis, every direction is zero
    queue_directed();
    queue_random(10);
    wait_drained();

    cfg_all(vec3(0, 0, -16384), vec3(0, 16384, 0), vec3(16384, 0, 0), rnd64(),
            64'd6554, rnd64(), 64'd27146, 64'd455);
    queue_directed();
    hold_asked++;
    queue_random(60);
    wait_drained();

    cfg_all('1, {16'h0, 16'h8000, 16'h7FFF, 16'h8000}, {16'h0, 16'h7FFF, 16'h8000, 16'h7FFF},
            '1, '1, '1, '1, '1);
    queue_directed();
    queue_random(60);
    wait_drained();

    cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed();
    queue_random(20);
    wait_drained();

    quiet = 1'b1;
    cfg_all(vec3(rnd_lane(), rnd_lane(), rnd_lane()), vec3(rnd_lane(), rnd_lane(), rnd_lane()),
            vec3(rnd_lane(), rnd_lane(), rnd_lane()), rnd64(), $urandom_range(0, 1 << 20),
            rnd64(), $urandom_range(0, 1 << 18), $urandom_range(0, 1024));
    queue_random(80);
    wait_drained();
    quiet = 1'b0;

    cfg_all(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
    queue_directed();
    queue_random(60);
    wait_drained();

    cfg_all(vec3(rnd_lane(), rnd_lane(), rnd_lane()), vec3(rnd_lane(), rnd_lane(), rnd_lane()),
            vec3(rnd_lane(), rnd_lane(), rnd_lane()), rnd64(), $urandom, rnd64(),
            $urandom, $urandom);
    hold_asked++;
    queue_random(60);
    wait_drained();

    if (mismatches == 0 && ray_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/pcrg_pkg.sv
design/pcrg_norm.sv
design/pinhole_camera_ray_generator_unit.sv
verif/tb.sv
